// File: design/tbpc_pkg.sv
// shared types, constants and register codes for the two-button press controller
package tbpc_pkg;

    // timestamp width, differences wrap at this many bits
    localparam int TIME_BITS = 32;

    localparam int CFG_INDEX_BITS = 3;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    // configuration register indexes
    localparam cfg_index_t CFG_DEBOUNCE_MS      = 3'd0;
    localparam cfg_index_t CFG_LONG_PRESS_MS    = 3'd1;
    localparam cfg_index_t CFG_EFFECT_COUNT     = 3'd2;
    localparam cfg_index_t CFG_START_BRIGHTNESS = 3'd3;
    localparam cfg_index_t CFG_MAX_BRIGHTNESS   = 3'd4;

    // register reset values
    localparam logic [15:0] DEBOUNCE_MS_RST      = 16'd50;
    localparam logic [15:0] LONG_PRESS_MS_RST    = 16'd1000;
    localparam logic [7:0]  EFFECT_COUNT_RST     = 8'd8;
    localparam logic [7:0]  START_BRIGHTNESS_RST = 8'd102;
    localparam logic [7:0]  MAX_BRIGHTNESS_RST   = 8'd255;

    localparam logic [7:0]  BRIGHT_STEP = 8'd51;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_DEBOUNCE = 3'd1,
        PH_PRESSED  = 3'd2,
        PH_RELEASED = 3'd3,
        PH_LONG     = 3'd4,
        PH_LONGREAD = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } event_t;

    // timing registers seen by each button lane
    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] long_press_ms;
    } lane_cfg_t;

    // one result beat, without the scaled level
    typedef struct packed {
        event_t      mode_event;
        event_t      bright_event;
        logic [7:0]  effect_index;
        logic        auto_cycle_on;
        logic [7:0]  brightness_setting;
        logic        effect_restart;
        logic        auto_toggled;
        logic        save_request;
    } result_t;

endpackage

// File: design/tbpc_button_lane.sv
// one button lane: debounce and short/long press state machine
module tbpc_button_lane
    import tbpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic [TIME_BITS-1:0] time_ms,
    input  logic                 pin,
    input  lane_cfg_t            cfg,
    output event_t               press_event
);

    phase_t               phase_reg;
    phase_t               phase_next;
    phase_t               phase_mid;
    logic [TIME_BITS-1:0] stamp_reg;
    logic [TIME_BITS-1:0] stamp_next;
    logic [TIME_BITS-1:0] elapsed;
    logic                 low;
    logic                 debounce_done;
    logic                 long_done;

    assign low           = ~pin;
    assign elapsed       = time_ms - stamp_reg;
    assign debounce_done = elapsed > TIME_BITS'(cfg.debounce_ms);
    assign long_done     = elapsed > TIME_BITS'(cfg.long_press_ms);

    // next state; released and long press are consumed in the same beat
    always_comb
    begin
        phase_mid  = phase_reg;
        stamp_next = stamp_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (low)
                begin
                    stamp_next = time_ms;
                    phase_mid  = PH_DEBOUNCE;
                end
            end
            PH_DEBOUNCE:
            begin
                if (debounce_done && low)
                begin
                    phase_mid = PH_PRESSED;
                end
            end
            PH_PRESSED:
            begin
                priority if (!low)
                begin
                    phase_mid = PH_RELEASED;
                end
                else if (long_done)
                begin
                    phase_mid = PH_LONG;
                end
            end
            PH_LONGREAD:
            begin
                if (!low)
                begin
                    phase_mid = PH_IDLE;
                end
            end
            default:
            begin
                phase_mid = phase_reg;
            end
        endcase

        unique case (phase_mid)
            PH_RELEASED: phase_next = PH_IDLE;
            PH_LONG:     phase_next = PH_LONGREAD;
            default:     phase_next = phase_mid;
        endcase
    end

    // event output
    always_comb
    begin
        unique case (phase_mid)
            PH_RELEASED: press_event = EV_SHORT;
            PH_LONG:     press_event = EV_LONG;
            default:     press_event = EV_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            stamp_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            stamp_reg <= stamp_next;
        end
    end

    // transient phases never get stored
    a_no_transient_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_RELEASED) && (phase_reg != PH_LONG))
        else $error("transient press phase stored");

    // a long event leaves the lane waiting for release
    a_long_then_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && press_event == EV_LONG) |=> (phase_reg == PH_LONGREAD))
        else $error("long event did not park lane in long press read");

endmodule

// File: design/tbpc_merge.sv
// merging stage: applies both lanes' events to the effect and brightness settings
module tbpc_merge
    import tbpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  event_t     mode_ev,
    input  event_t     bright_ev,
    input  logic [7:0] effect_count,
    input  logic [7:0] start_brightness,
    output result_t    result
);

    logic [7:0] effect_reg;
    logic [7:0] effect_next;
    logic [7:0] effect_inc;
    logic       auto_reg;
    logic       auto_next;
    logic [7:0] bright_reg;
    logic [7:0] bright_next;

    assign effect_inc = effect_reg + 8'd1;

    always_comb
    begin
        effect_next = effect_reg;
        auto_next   = auto_reg;
        bright_next = bright_reg;

        unique case (mode_ev)
            EV_SHORT: effect_next = (effect_inc >= effect_count) ? 8'd0 : effect_inc;
            EV_LONG:  auto_next   = ~auto_reg;
            default:  effect_next = effect_reg;
        endcase

        unique case (bright_ev)
            EV_SHORT: bright_next = bright_reg + BRIGHT_STEP;
            EV_LONG:  bright_next = start_brightness;
            default:  bright_next = bright_reg;
        endcase
    end

    always_comb
    begin
        result.mode_event         = mode_ev;
        result.bright_event       = bright_ev;
        result.effect_index       = effect_next;
        result.auto_cycle_on      = auto_next;
        result.brightness_setting = bright_next;
        result.effect_restart     = (mode_ev == EV_SHORT);
        result.auto_toggled       = (mode_ev == EV_LONG);
        result.save_request       = (mode_ev != EV_NONE) || (bright_ev != EV_NONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            effect_reg <= '0;
            auto_reg   <= 1'b0;
            bright_reg <= START_BRIGHTNESS_RST;
        end
        else if (advance)
        begin
            effect_reg <= effect_next;
            auto_reg   <= auto_next;
            bright_reg <= bright_next;
        end
    end

    // brightness long press reloads the start value
    a_bright_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && bright_ev == EV_LONG) |=> (bright_reg == $past(start_brightness)))
        else $error("brightness long press did not reload start value");

    // auto flag only moves on a mode long press
    a_auto_only_long: assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && mode_ev == EV_LONG) |=> (auto_reg == $past(auto_reg)))
        else $error("auto cycle flag changed without long press");

endmodule

// File: design/two_button_press_controller.sv
// top level: two button lanes, settings merge, output register and config port
//
// Two-button press controller. Each input beat is one poll tick carrying a
// millisecond timestamp and two active-low button levels. Both buttons are
// debounced and classified as short or long presses in parallel lanes, and the
// merged events step the effect index, the auto-cycle flag and the brightness
// setting. A tick is accepted on any clock edge with in_valid high and
// in_stall low, one tick per clock sustained; its result beat appears in the
// output register on the following cycle. The lane state update and the
// settings merge are both formed combinationally from the registered state,
// so the next accepted tick sees the updated state at once. in_stall is raised
// only while a finished result waits and out_stall holds it. The scaled
// brightness level is formed from the registered setting and max_brightness
// by an 8x8 multiply on the output side. Config writes are always ready and
// are meant for times when no beat is in flight.
module two_button_press_controller
    import tbpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    // config write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  cfg_index_t           cfg_index,
    input  logic [15:0]          cfg_data,

    // tick input
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [TIME_BITS-1:0] time_ms,
    input  logic                 mode_pin,
    input  logic                 bright_pin,

    // result output
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           mode_event,
    output logic [1:0]           bright_event,
    output logic [7:0]           effect_index,
    output logic                 auto_cycle_on,
    output logic [7:0]           brightness_setting,
    output logic [7:0]           brightness_level,
    output logic                 effect_restart,
    output logic                 cycle_restart,
    output logic                 auto_toggled,
    output logic                 save_request
);

    // config registers
    logic [15:0] debounce_ms_reg;
    logic [15:0] long_press_ms_reg;
    logic [7:0]  effect_count_reg;
    logic [7:0]  start_brightness_reg;
    logic [7:0]  max_brightness_reg;

    lane_cfg_t   lane_cfg;
    logic        advance;
    event_t      mode_ev;
    event_t      bright_ev;
    result_t     result;

    // output register
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     out_data_reg;
    logic [15:0] level_product;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms_reg      <= DEBOUNCE_MS_RST;
            long_press_ms_reg    <= LONG_PRESS_MS_RST;
            effect_count_reg     <= EFFECT_COUNT_RST;
            start_brightness_reg <= START_BRIGHTNESS_RST;
            max_brightness_reg   <= MAX_BRIGHTNESS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE_MS:      debounce_ms_reg      <= cfg_data;
                CFG_LONG_PRESS_MS:    long_press_ms_reg    <= cfg_data;
                CFG_EFFECT_COUNT:     effect_count_reg     <= cfg_data[7:0];
                CFG_START_BRIGHTNESS: start_brightness_reg <= cfg_data[7:0];
                CFG_MAX_BRIGHTNESS:   max_brightness_reg   <= cfg_data[7:0];
                default:              debounce_ms_reg      <= debounce_ms_reg;
            endcase
        end
    end

    assign lane_cfg.debounce_ms   = debounce_ms_reg;
    assign lane_cfg.long_press_ms = long_press_ms_reg;

    // take a tick unless a finished beat is held by the consumer
    assign in_stall = out_valid_reg && out_stall;
    assign advance  = in_valid && !in_stall;

    tbpc_button_lane u_mode_lane (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .time_ms     (time_ms),
        .pin         (mode_pin),
        .cfg         (lane_cfg),
        .press_event (mode_ev)
    );

    tbpc_button_lane u_bright_lane (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .time_ms     (time_ms),
        .pin         (bright_pin),
        .cfg         (lane_cfg),
        .press_event (bright_ev)
    );

    tbpc_merge u_merge (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (advance),
        .mode_ev          (mode_ev),
        .bright_ev        (bright_ev),
        .effect_count     (effect_count_reg),
        .start_brightness (start_brightness_reg),
        .result           (result)
    );

    // output valid: load on accept, drop once taken
    always_comb
    begin
        priority if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    // scaled level; max_brightness is to be changed only while no beat is pending, which the block does not enforce
    assign level_product = 16'(out_data_reg.brightness_setting) * 16'(max_brightness_reg);

    assign out_valid          = out_valid_reg;
    assign mode_event         = out_data_reg.mode_event;
    assign bright_event       = out_data_reg.bright_event;
    assign effect_index       = out_data_reg.effect_index;
    assign auto_cycle_on      = out_data_reg.auto_cycle_on;
    assign brightness_setting = out_data_reg.brightness_setting;
    assign brightness_level   = level_product[15:8];
    assign effect_restart     = out_data_reg.effect_restart;
    assign cycle_restart      = out_data_reg.effect_restart;
    assign auto_toggled       = out_data_reg.auto_toggled;
    assign save_request       = out_data_reg.save_request;

    // a held beat is never overwritten by a new tick
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(out_data_reg))
        else $error("held result beat overwritten");

endmodule

// File: tb/two_button_press_controller_tb.sv
// testbench for the two-button press controller, self-checking against its own predictor
`timescale 1ns / 100ps

module two_button_press_controller_tb;
    import tbpc_pkg::*;

    localparam int REPORT_LIMIT      = 10;
    localparam int SETTLE_CYCLES     = 4;
    localparam int LONG_HOLD_CYCLES  = 80;
    localparam int TICKS_PER_SETTING = 240;

    // full result beat as seen on the output ports
    typedef struct packed {
        logic [1:0] mode_event;
        logic [1:0] bright_event;
        logic [7:0] effect_index;
        logic       auto_cycle_on;
        logic [7:0] brightness_setting;
        logic [7:0] brightness_level;
        logic       effect_restart;
        logic       cycle_restart;
        logic       auto_toggled;
        logic       save_request;
    } tick_result_t;

    // one row of the directed table; typed rows carry a hand-written result
    typedef struct packed {
        logic [TIME_BITS-1:0] stamp;
        logic                 mode;
        logic                 bright;
        logic                 typed;
        tick_result_t         want;
    } directed_row_t;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_t;
    typedef enum int {PRESS_TAP, PRESS_SHORT, PRESS_LONG} press_kind_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    cfg_index_t           cfg_index    = CFG_DEBOUNCE_MS;
    logic [15:0]          cfg_data     = 16'd0;
    logic                 in_valid     = 1'b0;
    logic                 in_stall;
    logic [TIME_BITS-1:0] time_ms      = '0;
    logic                 mode_pin     = 1'b1;
    logic                 bright_pin   = 1'b1;
    logic                 out_valid;
    logic                 out_stall    = 1'b0;
    logic [1:0]           mode_event;
    logic [1:0]           bright_event;
    logic [7:0]           effect_index;
    logic                 auto_cycle_on;
    logic [7:0]           brightness_setting;
    logic [7:0]           brightness_level;
    logic                 effect_restart;
    logic                 cycle_restart;
    logic                 auto_toggled;
    logic                 save_request;

    two_button_press_controller dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .time_ms            (time_ms),
        .mode_pin           (mode_pin),
        .bright_pin         (bright_pin),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .mode_event         (mode_event),
        .bright_event       (bright_event),
        .effect_index       (effect_index),
        .auto_cycle_on      (auto_cycle_on),
        .brightness_setting (brightness_setting),
        .brightness_level   (brightness_level),
        .effect_restart     (effect_restart),
        .cycle_restart      (cycle_restart),
        .auto_toggled       (auto_toggled),
        .save_request       (save_request)
    );

    // 12 ns clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // predictor: shadow registers and controller state
    // ---------------------------------------------------------------
    logic [15:0]          set_debounce     = DEBOUNCE_MS_RST;
    logic [15:0]          set_long_press   = LONG_PRESS_MS_RST;
    logic [7:0]           set_effect_count = EFFECT_COUNT_RST;
    logic [7:0]           set_start_bright = START_BRIGHTNESS_RST;
    logic [7:0]           set_max_bright   = MAX_BRIGHTNESS_RST;

    phase_t               lane_phase [2]   = '{PH_IDLE, PH_IDLE};
    logic [TIME_BITS-1:0] lane_stamp [2]   = '{'0, '0};
    logic [7:0]           cur_effect       = 8'd0;
    logic                 cur_auto         = 1'b0;
    // the brightness setting is loaded once at reset and never on a register write
    logic [7:0]           cur_bright       = START_BRIGHTNESS_RST;

    // one button lane: step the phase, then take up a short or long event at once
    function automatic event_t lane_step(input int b, input logic [TIME_BITS-1:0] now,
                                         input logic low);
        logic [TIME_BITS-1:0] elapsed;
        elapsed = now - lane_stamp[b];
        case (lane_phase[b])
            PH_IDLE:
                if (low)
                begin
                    lane_stamp[b] = now;
                    lane_phase[b] = PH_DEBOUNCE;
                end
            // a high pin does not abort debouncing
            PH_DEBOUNCE:
                if (elapsed > set_debounce && low)
                    lane_phase[b] = PH_PRESSED;
            PH_PRESSED:
                if (!low)
                    lane_phase[b] = PH_RELEASED;
                else if (elapsed > set_long_press)
                    lane_phase[b] = PH_LONG;
            PH_LONGREAD:
                if (!low)
                    lane_phase[b] = PH_IDLE;
            default: ;
        endcase
        if (lane_phase[b] == PH_RELEASED)
        begin
            lane_phase[b] = PH_IDLE;
            return EV_SHORT;
        end
        if (lane_phase[b] == PH_LONG)
        begin
            lane_phase[b] = PH_LONGREAD;
            return EV_LONG;
        end
        return EV_NONE;
    endfunction

    function automatic tick_result_t tick_outcome(input logic [TIME_BITS-1:0] now,
                                                  input logic mode_level,
                                                  input logic bright_level);
        tick_result_t r;
        logic [15:0]  product;
        r = '0;
        r.mode_event   = lane_step(0, now, !mode_level);
        r.bright_event = lane_step(1, now, !bright_level);

        if (r.mode_event == EV_SHORT)
        begin
            // 8-bit increment, then back to zero at or past the count
            cur_effect = cur_effect + 8'd1;
            if (cur_effect >= set_effect_count)
                cur_effect = 8'd0;
            r.effect_restart = 1'b1;
            r.cycle_restart  = 1'b1;
            r.save_request   = 1'b1;
        end
        else if (r.mode_event == EV_LONG)
        begin
            cur_auto       = ~cur_auto;
            r.auto_toggled = 1'b1;
            r.save_request = 1'b1;
        end

        if (r.bright_event == EV_SHORT)
        begin
            cur_bright     = cur_bright + BRIGHT_STEP;
            r.save_request = 1'b1;
        end
        else if (r.bright_event == EV_LONG)
        begin
            cur_bright     = set_start_bright;
            r.save_request = 1'b1;
        end

        product              = cur_bright * set_max_bright;
        r.effect_index       = cur_effect;
        r.auto_cycle_on      = cur_auto;
        r.brightness_setting = cur_bright;
        r.brightness_level   = product[15:8];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // scoreboard: predict on every accepted tick, check every result beat
    // ---------------------------------------------------------------
    tick_result_t outcomes_due [$];
    logic         tick_typed = 1'b0;
    tick_result_t tick_want  = '0;
    int           error_count    = 0;
    int           ticks_accepted = 0;
    int           results_seen   = 0;
    int           short_presses  = 0;
    int           long_presses   = 0;
    int           setting_writes = 0;

    task automatic report_field(input string field, input logic [7:0] want_v,
                                input logic [7:0] got_v);
        if (error_count < REPORT_LIMIT)
            $display("mismatch on %s in result %0d: expected %0d, got %0d",
                     field, results_seen, want_v, got_v);
        error_count++;
    endtask

    always @(posedge clk)
    begin : tick_tracker
        tick_result_t predicted;
        tick_result_t want;
        tick_result_t got;
        // the expectation goes in before the check so a same-edge result still finds it
        if (in_valid && !in_stall)
        begin
            predicted = tick_outcome(time_ms, mode_pin, bright_pin);
            outcomes_due.push_back(tick_typed ? tick_want : predicted);
            ticks_accepted++;
            short_presses += (predicted.mode_event == EV_SHORT)
                           + (predicted.bright_event == EV_SHORT);
            long_presses  += (predicted.mode_event == EV_LONG)
                           + (predicted.bright_event == EV_LONG);
        end
        if (out_valid && !out_stall)
        begin
            if (outcomes_due.size() == 0)
            begin
                if (error_count < REPORT_LIMIT)
                    $display("result beat %0d arrived with nothing expected", results_seen);
                error_count++;
            end
            else
            begin
                want = outcomes_due.pop_front();
                got.mode_event         = mode_event;
                got.bright_event       = bright_event;
                got.effect_index       = effect_index;
                got.auto_cycle_on      = auto_cycle_on;
                got.brightness_setting = brightness_setting;
                got.brightness_level   = brightness_level;
                got.effect_restart     = effect_restart;
                got.cycle_restart      = cycle_restart;
                got.auto_toggled       = auto_toggled;
                got.save_request       = save_request;
                if (got.mode_event !== want.mode_event)
                    report_field("mode_event", want.mode_event, got.mode_event);
                if (got.bright_event !== want.bright_event)
                    report_field("bright_event", want.bright_event, got.bright_event);
                if (got.effect_index !== want.effect_index)
                    report_field("effect_index", want.effect_index, got.effect_index);
                if (got.auto_cycle_on !== want.auto_cycle_on)
                    report_field("auto_cycle_on", want.auto_cycle_on, got.auto_cycle_on);
                if (got.brightness_setting !== want.brightness_setting)
                    report_field("brightness_setting", want.brightness_setting,
                                 got.brightness_setting);
                if (got.brightness_level !== want.brightness_level)
                    report_field("brightness_level", want.brightness_level,
                                 got.brightness_level);
                if (got.effect_restart !== want.effect_restart)
                    report_field("effect_restart", want.effect_restart, got.effect_restart);
                if (got.cycle_restart !== want.cycle_restart)
                    report_field("cycle_restart", want.cycle_restart, got.cycle_restart);
                if (got.auto_toggled !== want.auto_toggled)
                    report_field("auto_toggled", want.auto_toggled, got.auto_toggled);
                if (got.save_request !== want.save_request)
                    report_field("save_request", want.save_request, got.save_request);
            end
            results_seen++;
        end
    end

    // ---------------------------------------------------------------
    // receiver: stall patterns that change every so often, plus a long hold on request
    // ---------------------------------------------------------------
    stall_style_t stall_style   = STALL_NONE;
    int           style_left    = 0;
    int           hold_left     = 0;
    logic         hold_request  = 1'b0;

    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = LONG_HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            // long hold: the block fills up and must stall its input
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (style_left == 0)
            begin
                stall_style = stall_style_t'($urandom_range(0, 3));
                style_left  = $urandom_range(32, 200);
            end
            style_left--;
            case (stall_style)
                STALL_NONE:     out_stall <= 1'b0;
                STALL_LIGHT:    out_stall <= ($urandom_range(0, 7) == 0);
                STALL_HEAVY:    out_stall <= $urandom_range(0, 1);
                STALL_PERIODIC: out_stall <= (style_left % 3 == 0);
                default:        out_stall <= 1'b0;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // sender side
    // ---------------------------------------------------------------

    // present one tick beat and hold it until the block takes it
    task automatic offer_tick(input logic [TIME_BITS-1:0] t, input logic m, input logic b,
                              input logic typed, input tick_result_t want);
        in_valid   <= 1'b1;
        time_ms    <= t;
        mode_pin   <= m;
        bright_pin <= b;
        tick_typed <= typed;
        tick_want  <= want;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // let every expected beat come back, then wait out SETTLE_CYCLES for anything still in flight;
    // an edge is taken first so the tracker has booked the tick taken at the current edge
    task automatic wait_for_outcomes();
        @(posedge clk);
        while (outcomes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register write; cfg_valid stays up so back-to-back writes need one drive per step
    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_DEBOUNCE_MS:      set_debounce     = val;
            CFG_LONG_PRESS_MS:    set_long_press   = val;
            CFG_EFFECT_COUNT:     set_effect_count = val[7:0];
            CFG_START_BRIGHTNESS: set_start_bright = val[7:0];
            CFG_MAX_BRIGHTNESS:   set_max_bright   = val[7:0];
            default: ;
        endcase
        setting_writes++;
    endtask

    // all five registers; the upper byte of the 8-bit ones carries junk that must be ignored
    task automatic load_settings(input logic [15:0] d_ms, input logic [15:0] l_ms,
                                 input logic [7:0] n_fx, input logic [7:0] s_br,
                                 input logic [7:0] m_br);
        logic [7:0] pad;
        write_reg(CFG_DEBOUNCE_MS, d_ms);
        write_reg(CFG_LONG_PRESS_MS, l_ms);
        pad = $urandom_range(0, 255);
        write_reg(CFG_EFFECT_COUNT, {pad, n_fx});
        pad = $urandom_range(0, 255);
        write_reg(CFG_START_BRIGHTNESS, {pad, s_br});
        pad = $urandom_range(0, 255);
        write_reg(CFG_MAX_BRIGHTNESS, {pad, m_br});
        cfg_valid <= 1'b0;
    endtask

    // random press scripts: each button plays taps, short and long presses,
    // sometimes with contact bounce, with a little noise and some timestamp jumps
    logic [TIME_BITS-1:0] now_ms;
    logic                 plan_live   [2] = '{1'b0, 1'b0};
    logic [TIME_BITS-1:0] plan_start  [2];
    int unsigned          plan_len    [2];
    logic                 plan_bounce [2];

    task automatic run_presses(input int count, input logic pressure);
        int          i;
        int          b;
        int          gap;
        int          burst_left;
        int unsigned span;
        int unsigned dt;
        int unsigned held;
        int unsigned lo;
        int unsigned hi;
        logic [1:0]  pins;
        logic        fresh;
        press_kind_t kind;
        burst_left = 0;
        for (i = 0; i < count; i++)
        begin
            if (pressure && i == count / 3)
                hold_request = 1'b1;
            if (pressure && i == 2 * count / 3)
            begin
                // sender pauses until the pipeline is empty
                in_valid <= 1'b0;
                wait_for_outcomes();
            end
            else if (burst_left == 0)
            begin
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                         : $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                // keep offering while the receiver holds off
                if (pressure && i >= count / 3 && i < count / 3 + 40)
                    gap = 0;
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            if (burst_left > 0)
                burst_left--;

            span = set_debounce + set_long_press + 2;
            dt   = $urandom_range(0, span / 5 + 1);
            if ($urandom_range(0, 59) == 0)
                now_ms = $urandom;
            else
                now_ms = now_ms + dt;

            for (b = 0; b < 2; b++)
            begin
                held  = now_ms - plan_start[b];
                fresh = 1'b0;
                if (plan_live[b])
                begin
                    if (held >= plan_len[b])
                        plan_live[b] = 1'b0;
                end
                else if ($urandom_range(0, 2) == 0)
                begin
                    plan_live[b]   = 1'b1;
                    plan_start[b]  = now_ms;
                    plan_bounce[b] = ($urandom_range(0, 3) == 0);
                    fresh          = 1'b1;
                    kind           = press_kind_t'($urandom_range(0, 2));
                    case (kind)
                        PRESS_TAP:
                            plan_len[b] = $urandom_range(0, set_debounce);
                        PRESS_SHORT:
                        begin
                            lo = set_debounce + 1;
                            hi = (set_long_press > lo) ? set_long_press : lo;
                            plan_len[b] = $urandom_range(lo, hi);
                        end
                        default:
                            plan_len[b] = set_long_press + 1
                                        + $urandom_range(0, set_long_press / 2 + 50);
                    endcase
                end
                if (!plan_live[b])
                    pins[b] = 1'b1;
                else if (fresh)
                    pins[b] = 1'b0;
                else if (plan_bounce[b] && held <= set_debounce)
                    pins[b] = $urandom_range(0, 1);
                else
                    pins[b] = 1'b0;
            end
            // now and then the levels are plain noise
            if ($urandom_range(0, 9) == 0)
                pins = $urandom_range(0, 3);

            offer_tick(now_ms, pins[0], pins[1], 1'b0, '0);
        end
    endtask

    // directed table
    directed_row_t directed_rows [$];

    task automatic add_row(input logic [TIME_BITS-1:0] t, input logic m, input logic b,
                           input logic typed, input tick_result_t want);
        directed_row_t row;
        row.stamp  = t;
        row.mode   = m;
        row.bright = b;
        row.typed  = typed;
        row.want   = want;
        directed_rows.push_back(row);
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial
    begin
        int          p;
        logic [15:0] d_ms;
        logic [15:0] l_ms;
        logic [7:0]  n_fx;
        logic [7:0]  s_br;
        logic [7:0]  m_br;

        // idle tick straight after reset shows every reset value
        add_row(32'd0, 1'b1, 1'b1, 1'b1,
                {EV_NONE, EV_NONE, 8'd0, 1'b0, 8'd102, 8'd101, 1'b0, 1'b0, 1'b0, 1'b0});
        // mode short press, with the pin going high while still debouncing
        add_row(32'd10, 1'b0, 1'b1, 1'b0, '0);
        add_row(32'd40, 1'b1, 1'b1, 1'b0, '0);
        add_row(32'd61, 1'b0, 1'b1, 1'b0, '0);
        add_row(32'd70, 1'b1, 1'b1, 1'b1,
                {EV_SHORT, EV_NONE, 8'd1, 1'b0, 8'd102, 8'd101, 1'b1, 1'b1, 1'b0, 1'b1});
        // brightness long press; elapsed equal to the debounce time does not confirm
        add_row(32'd100, 1'b1, 1'b0, 1'b0, '0);
        add_row(32'd150, 1'b1, 1'b0, 1'b0, '0);
        add_row(32'd151, 1'b1, 1'b0, 1'b0, '0);
        add_row(32'd1101, 1'b1, 1'b0, 1'b1,
                {EV_NONE, EV_LONG, 8'd1, 1'b0, 8'd102, 8'd101, 1'b0, 1'b0, 1'b0, 1'b1});
        add_row(32'd1200, 1'b1, 1'b0, 1'b0, '0);
        add_row(32'd1300, 1'b1, 1'b1, 1'b0, '0);
        // both buttons at once: brightness short, then mode long
        add_row(32'd2000, 1'b0, 1'b0, 1'b0, '0);
        add_row(32'd2051, 1'b0, 1'b0, 1'b0, '0);
        add_row(32'd2060, 1'b0, 1'b1, 1'b0, '0);
        add_row(32'd3001, 1'b0, 1'b1, 1'b1,
                {EV_LONG, EV_NONE, 8'd1, 1'b1, 8'd153, 8'd152, 1'b0, 1'b0, 1'b1, 1'b1});
        add_row(32'd3002, 1'b1, 1'b1, 1'b0, '0);
        // press that spans the timestamp wrap
        add_row(32'hFFFF_FFF0, 1'b1, 1'b0, 1'b0, '0);
        add_row(32'h0000_0030, 1'b1, 1'b0, 1'b0, '0);
        add_row(32'h0000_0031, 1'b1, 1'b1, 1'b0, '0);
        add_row(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, '0);
        // one more brightness short press up to full scale
        add_row(32'd100, 1'b1, 1'b0, 1'b0, '0);
        add_row(32'd200, 1'b1, 1'b0, 1'b0, '0);
        add_row(32'd201, 1'b1, 1'b1, 1'b0, '0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer_tick(directed_rows[i].stamp, directed_rows[i].mode, directed_rows[i].bright,
                       directed_rows[i].typed, directed_rows[i].want);
        in_valid <= 1'b0;
        wait_for_outcomes();

        // settings walk: both extremes, an index left past a smaller count, count zero, a fixed set
        // run under receiver pressure, then random settings
        for (p = 0; p < 7; p++)
        begin
            now_ms = $urandom;
            case (p)
                0: begin d_ms = 16'd0;     l_ms = 16'd0;     n_fx = 8'd1;
                         s_br = 8'd0;      m_br = 8'd0;      end
                1: begin d_ms = 16'hFFFF;  l_ms = 16'hFFFF;  n_fx = 8'd255;
                         s_br = 8'd255;    m_br = 8'd255;
                         now_ms = 32'hFFFE_0000;             end
                2: begin d_ms = 16'd40;    l_ms = 16'd300;   n_fx = 8'd3;
                         s_br = 8'd200;    m_br = 8'd128;    end
                3: begin d_ms = 16'd0;     l_ms = 16'hFFFF;  n_fx = 8'd0;
                         s_br = 8'd17;     m_br = 8'd1;      end
                4: begin d_ms = 16'd10;    l_ms = 16'd120;   n_fx = 8'd6;
                         s_br = 8'd51;     m_br = 8'd77;     end
                default:
                begin
                    d_ms = $urandom_range(0, 400);
                    l_ms = $urandom_range(0, 3000);
                    n_fx = $urandom_range(1, 255);
                    s_br = $urandom_range(0, 255);
                    m_br = $urandom_range(0, 255);
                end
            endcase
            load_settings(d_ms, l_ms, n_fx, s_br, m_br);
            run_presses(TICKS_PER_SETTING, p == 4);
            in_valid <= 1'b0;
            wait_for_outcomes();
        end

        $display("covered %0d ticks under %0d register writes: %0d short and %0d long presses",
                 ticks_accepted, setting_writes, short_presses, long_presses);
        if (error_count == 0 && outcomes_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
